### src/cmvp_pkg.sv
`timescale 1ns / 1ps
// Package for the chained matrix-vector product block.
// Holds the shared widths, command and register codes, pipeline structs and
// the saturation function. It depends on nothing else.
package cmvp_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * DATA_W - FRAC_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int ROW_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int FUNC_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_OUT     = 8;
  localparam int DEF_MAX_DIM = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_Q    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_R    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RINV = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_X    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 1'd1;

  localparam logic [SIZE_W-1:0]        SIZE_RESET  = 4'd8;
  localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sh0001_0000;

  localparam logic signed [ACC_W-1:0] ACC_SAT_HI = ACC_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [ACC_W-1:0] ACC_SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE_A,
    ST_DRAIN,
    ST_PHASE_B,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             phase_b;
    logic             lam;
    logic             tail;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } issue_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             phase_b;
    logic             lam;
    logic             tail;
    logic [ROW_W-1:0] row;
  } stage_t;

  typedef struct packed {
    logic                     valid;
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] rinvx;
  } wb_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_SAT_HI) begin
      return ACC_SAT_HI[DATA_W-1:0];
    end else if (v < ACC_SAT_LO) begin
      return ACC_SAT_LO[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### src/chained_matrix_vector_product.sv
`timescale 1ns / 1ps
// Top level of the chained matrix-vector product block.
// Holds the configuration registers and connects sequencer, memories and datapath.
// Depends on cmvp_pkg, cmvp_seq, cmvp_store and cmvp_mac.
//
// A command is taken at a rising edge where start is high and busy is low. A load
// writes one element in that cycle and leaves busy low. A compute raises busy while
// it forms R*x and R_inv*x, one multiply-add per cycle on each of two multipliers fed
// by one read port per memory, then the Q products and the lambda products row by
// row, with a pipeline drain between the passes and at the end. Row i is shown on
// the result ports with strobe_o high for a single cycle; the receiver cannot stall,
// so every transfer happens in that cycle. Configuration writes are meant for times
// when busy is low.
module chained_matrix_vector_product #(
  parameter int MAX_DIM = cmvp_pkg::DEF_MAX_DIM
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cmvp_pkg::FUNC_W-1:0]        func_i,
  input  logic [cmvp_pkg::ROW_W-1:0]         row_index_i,
  input  logic [cmvp_pkg::ROW_W-1:0]         col_index_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] element_value_i,
  input  logic                               cfg_we_i,
  input  logic [cmvp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cmvp_pkg::DATA_W-1:0]        cfg_data_i,
  output logic                               strobe_o,
  output logic [cmvp_pkg::ROW_W-1:0]         out_row_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] q_rx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] lambda_rx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] q_rinvx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] lambda_rinvx_o,
  output logic                               last_row_o
);

  logic [cmvp_pkg::SIZE_W-1:0]        matrix_size_q;
  logic signed [cmvp_pkg::DATA_W-1:0] scale_q;
  logic                               accept, mac_active, pipe_empty;
  logic [cmvp_pkg::SIZE_W-1:0]        n;
  cmvp_pkg::issue_t                   issue;
  cmvp_pkg::stage_t                   stage1;
  cmvp_pkg::wb_t                      wb;
  logic signed [cmvp_pkg::DATA_W-1:0] mat0, mat1, vec0, vec1;

  assign accept     = start && !busy;
  assign pipe_empty = !stage1.valid && !mac_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= cmvp_pkg::SIZE_RESET;
      scale_q       <= cmvp_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmvp_pkg::REG_MATRIX_SIZE: matrix_size_q <= cfg_data_i[cmvp_pkg::SIZE_W-1:0];
        cmvp_pkg::REG_SCALE:       scale_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmvp_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_i),
    .matrix_size_i(matrix_size_q),
    .pipe_empty_i (pipe_empty),
    .busy_o       (busy),
    .n_o          (n),
    .issue_o      (issue)
  );

  cmvp_store #(
    .MAX_DIM(MAX_DIM)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && (n != '0)),
    .func_i         (func_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .issue_i        (issue),
    .wb_i           (wb),
    .stage_o        (stage1),
    .mat0_o         (mat0),
    .mat1_o         (mat1),
    .vec0_o         (vec0),
    .vec1_o         (vec1)
  );

  cmvp_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage1),
    .mat0_i        (mat0),
    .mat1_i        (mat1),
    .vec0_i        (vec0),
    .vec1_i        (vec1),
    .scale_i       (scale_q),
    .active_o      (mac_active),
    .wb_o          (wb),
    .strobe_o      (strobe_o),
    .out_row_o     (out_row_o),
    .q_rx_o        (q_rx_o),
    .lambda_rx_o   (lambda_rx_o),
    .q_rinvx_o     (q_rinvx_o),
    .lambda_rinvx_o(lambda_rinvx_o),
    .last_row_o    (last_row_o)
  );

endmodule

### src/cmvp_seq.sv
`timescale 1ns / 1ps
// Sequencer of the chained matrix-vector product block.
// Walks rows and columns of both passes and issues one memory access per cycle during each pass.
// Depends on cmvp_pkg.
module cmvp_seq #(
  parameter int MAX_DIM = cmvp_pkg::DEF_MAX_DIM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [cmvp_pkg::FUNC_W-1:0]    func_i,
  input  logic [cmvp_pkg::SIZE_W-1:0]    matrix_size_i,
  input  logic                           pipe_empty_i,
  output logic                           busy_o,
  output logic [cmvp_pkg::SIZE_W-1:0]    n_o,
  output cmvp_pkg::issue_t               issue_o
);

  localparam int Lim = (MAX_DIM < cmvp_pkg::MAX_OUT) ? MAX_DIM : cmvp_pkg::MAX_OUT;

  cmvp_pkg::state_e state_q, state_d;
  logic [cmvp_pkg::SIZE_W-1:0] n_q, n_d;
  logic [cmvp_pkg::SIZE_W-1:0] n_m1;
  logic [cmvp_pkg::ROW_W-1:0]  i_q, i_d;
  logic [cmvp_pkg::SIZE_W-1:0] j_q, j_d;
  logic                        row_end_a, row_end_b, last_row;

  assign n_m1      = n_q - 4'd1;
  assign last_row  = ({1'b0, i_q} == n_m1);
  assign row_end_a = (j_q == n_m1);
  assign row_end_b = (j_q == n_q);

  always_comb begin
    if (matrix_size_i == '0) begin
      n_d = 4'd1;
    end else if (int'(matrix_size_i) > Lim) begin
      n_d = cmvp_pkg::SIZE_W'(Lim);
    end else begin
      n_d = matrix_size_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmvp_pkg::ST_IDLE: begin
        if (accept_i && func_i == cmvp_pkg::FUNC_COMPUTE) begin
          state_d = cmvp_pkg::ST_PHASE_A;
        end
      end
      cmvp_pkg::ST_PHASE_A: begin
        if (row_end_a && last_row) begin
          state_d = cmvp_pkg::ST_DRAIN;
        end
      end
      cmvp_pkg::ST_DRAIN: begin
        if (pipe_empty_i) begin
          state_d = cmvp_pkg::ST_PHASE_B;
        end
      end
      cmvp_pkg::ST_PHASE_B: begin
        if (row_end_b && last_row) begin
          state_d = cmvp_pkg::ST_FLUSH;
        end
      end
      cmvp_pkg::ST_FLUSH: begin
        if (pipe_empty_i) begin
          state_d = cmvp_pkg::ST_IDLE;
        end
      end
      default: state_d = cmvp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    unique case (state_q)
      cmvp_pkg::ST_PHASE_A: begin
        if (row_end_a) begin
          j_d = '0;
          i_d = i_q + 3'd1;
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      cmvp_pkg::ST_PHASE_B: begin
        if (row_end_b) begin
          j_d = '0;
          i_d = i_q + 3'd1;
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      default: begin
        i_d = '0;
        j_d = '0;
      end
    endcase
  end

  always_comb begin
    busy_o          = (state_q != cmvp_pkg::ST_IDLE);
    issue_o.valid   = 1'b0;
    issue_o.phase_b = 1'b0;
    issue_o.lam     = 1'b0;
    issue_o.first   = (j_q == '0);
    issue_o.last    = row_end_a;
    issue_o.tail    = last_row;
    issue_o.row     = i_q;
    issue_o.col     = j_q[cmvp_pkg::ROW_W-1:0];
    unique case (state_q)
      cmvp_pkg::ST_PHASE_A: begin
        issue_o.valid = 1'b1;
      end
      cmvp_pkg::ST_PHASE_B: begin
        issue_o.valid   = 1'b1;
        issue_o.phase_b = 1'b1;
        issue_o.lam     = row_end_b;
        issue_o.first   = (j_q == '0) || row_end_b;
        issue_o.last    = row_end_a || row_end_b;
      end
      default: begin
        issue_o.valid = 1'b0;
      end
    endcase
  end

  assign n_o = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmvp_pkg::ST_IDLE;
      n_q     <= 4'd1;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (state_q == cmvp_pkg::ST_IDLE && accept_i) begin
        n_q <= n_d;
      end
    end
  end

endmodule

### src/cmvp_store.sv
`timescale 1ns / 1ps
// Element memories of the chained matrix-vector product block.
// Holds Q, R, R_inv, x and the two intermediate vectors, with registered reads.
// Depends on cmvp_pkg.
module cmvp_store #(
  parameter int MAX_DIM = cmvp_pkg::DEF_MAX_DIM
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [cmvp_pkg::FUNC_W-1:0]       func_i,
  input  logic [cmvp_pkg::ROW_W-1:0]        row_index_i,
  input  logic [cmvp_pkg::ROW_W-1:0]        col_index_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] element_value_i,
  input  cmvp_pkg::issue_t                  issue_i,
  input  cmvp_pkg::wb_t                     wb_i,
  output cmvp_pkg::stage_t                  stage_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] mat0_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] mat1_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] vec0_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] vec1_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int VW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [cmvp_pkg::DATA_W-1:0] q_mem     [Depth];
  logic signed [cmvp_pkg::DATA_W-1:0] r_mem     [Depth];
  logic signed [cmvp_pkg::DATA_W-1:0] rinv_mem  [Depth];
  logic signed [cmvp_pkg::DATA_W-1:0] x_mem     [MAX_DIM];
  logic signed [cmvp_pkg::DATA_W-1:0] rx_mem    [MAX_DIM];
  logic signed [cmvp_pkg::DATA_W-1:0] rinvx_mem [MAX_DIM];

  logic [31:0]   load_lin, rd_lin, vrd_lin;
  logic          row_ok, col_ok;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] xwaddr, vraddr, wbaddr;
  cmvp_pkg::stage_t stage_q;

  assign load_lin = 32'(row_index_i) * 32'(MAX_DIM) + 32'(col_index_i);
  assign rd_lin   = 32'(issue_i.row) * 32'(MAX_DIM) + 32'(issue_i.col);
  assign vrd_lin  = issue_i.lam ? 32'(issue_i.row) : 32'(issue_i.col);
  assign row_ok   = (32'(row_index_i) < 32'(MAX_DIM));
  assign col_ok   = (32'(col_index_i) < 32'(MAX_DIM));
  assign waddr    = load_lin[AW-1:0];
  assign raddr    = rd_lin[AW-1:0];
  assign xwaddr   = VW'(32'(row_index_i));
  assign vraddr   = vrd_lin[VW-1:0];
  assign wbaddr   = VW'(32'(wb_i.row));

  always_ff @(posedge clk_i) begin
    if (load_i && row_ok && col_ok) begin
      unique case (func_i)
        cmvp_pkg::FUNC_LOAD_Q:    q_mem[waddr]    <= element_value_i;
        cmvp_pkg::FUNC_LOAD_R:    r_mem[waddr]    <= element_value_i;
        cmvp_pkg::FUNC_LOAD_RINV: rinv_mem[waddr] <= element_value_i;
        default: ;
      endcase
    end
    if (load_i && row_ok && func_i == cmvp_pkg::FUNC_LOAD_X) begin
      x_mem[xwaddr] <= element_value_i;
    end
    if (wb_i.valid) begin
      rx_mem[wbaddr]    <= wb_i.rx;
      rinvx_mem[wbaddr] <= wb_i.rinvx;
    end
    if (issue_i.valid) begin
      mat0_o <= issue_i.phase_b ? q_mem[raddr] : r_mem[raddr];
      mat1_o <= issue_i.phase_b ? q_mem[raddr] : rinv_mem[raddr];
      vec0_o <= issue_i.phase_b ? rx_mem[vraddr] : x_mem[vraddr];
      vec1_o <= issue_i.phase_b ? rinvx_mem[vraddr] : x_mem[vraddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q.valid   <= issue_i.valid;
      stage_q.first   <= issue_i.first;
      stage_q.last    <= issue_i.last;
      stage_q.phase_b <= issue_i.phase_b;
      stage_q.lam     <= issue_i.lam;
      stage_q.tail    <= issue_i.tail;
      stage_q.row     <= issue_i.row;
    end
  end

  assign stage_o = stage_q;

endmodule

### src/cmvp_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate datapath of the chained matrix-vector product block.
// Two Q16.16 multipliers, wide accumulators, saturation, write-back and results.
// Depends on cmvp_pkg.
module cmvp_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmvp_pkg::stage_t                   stage_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] mat0_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] mat1_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] vec0_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] vec1_i,
  input  logic signed [cmvp_pkg::DATA_W-1:0] scale_i,
  output logic                               active_o,
  output cmvp_pkg::wb_t                      wb_o,
  output logic                               strobe_o,
  output logic [cmvp_pkg::ROW_W-1:0]         out_row_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] q_rx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] lambda_rx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] q_rinvx_o,
  output logic signed [cmvp_pkg::DATA_W-1:0] lambda_rinvx_o,
  output logic                               last_row_o
);

  logic signed [cmvp_pkg::DATA_W-1:0]   a0, a1;
  logic signed [2*cmvp_pkg::DATA_W-1:0] full0, full1;
  logic signed [cmvp_pkg::PROD_W-1:0]   p0_q, p1_q;
  logic signed [cmvp_pkg::ACC_W-1:0]    acc0_q, acc1_q, acc0_d, acc1_d;
  logic signed [cmvp_pkg::DATA_W-1:0]   sat0, sat1, qa_q, qb_q;
  cmvp_pkg::stage_t                     s2_q, s3_q;
  logic                                 strobe_q;

  assign a0    = stage_i.lam ? scale_i : mat0_i;
  assign a1    = stage_i.lam ? scale_i : mat1_i;
  assign full0 = a0 * vec0_i;
  assign full1 = a1 * vec1_i;

  assign acc0_d = (s2_q.first ? '0 : acc0_q) + cmvp_pkg::ACC_W'(p0_q);
  assign acc1_d = (s2_q.first ? '0 : acc1_q) + cmvp_pkg::ACC_W'(p1_q);

  assign sat0 = cmvp_pkg::sat32(acc0_q);
  assign sat1 = cmvp_pkg::sat32(acc1_q);

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      p0_q <= full0[2*cmvp_pkg::DATA_W-1:cmvp_pkg::FRAC_W];
      p1_q <= full1[2*cmvp_pkg::DATA_W-1:cmvp_pkg::FRAC_W];
    end
    if (s2_q.valid) begin
      acc0_q <= acc0_d;
      acc1_q <= acc1_d;
    end
    if (s3_q.valid && s3_q.last && s3_q.phase_b && !s3_q.lam) begin
      qa_q <= sat0;
      qb_q <= sat1;
    end
    if (s3_q.valid && s3_q.lam) begin
      out_row_o      <= s3_q.row;
      q_rx_o         <= qa_q;
      lambda_rx_o    <= sat0;
      q_rinvx_o      <= qb_q;
      lambda_rinvx_o <= sat1;
      last_row_o     <= s3_q.tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q     <= '0;
      s3_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      s2_q     <= stage_i;
      s3_q     <= s2_q;
      strobe_q <= s3_q.valid && s3_q.lam;
    end
  end

  assign active_o    = s2_q.valid || s3_q.valid;
  assign strobe_o    = strobe_q;
  assign wb_o.valid  = s3_q.valid && s3_q.last && !s3_q.phase_b;
  assign wb_o.row    = s3_q.row;
  assign wb_o.rx     = sat0;
  assign wb_o.rinvx  = sat1;

endmodule

### dv/cmvp_checker.sv
`timescale 1ns / 1ps
// Checker for the chained matrix-vector product block. It watches the command, register and
// result transfers, predicts every result row and compares it. Depends on cmvp_pkg.
module cmvp_checker
  import cmvp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic [ROW_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     strobe_i,
  input  logic [ROW_W-1:0]         out_row_i,
  input  logic signed [DATA_W-1:0] q_rx_i,
  input  logic signed [DATA_W-1:0] lambda_rx_i,
  input  logic signed [DATA_W-1:0] q_rinvx_i,
  input  logic signed [DATA_W-1:0] lambda_rinvx_i,
  input  logic                     last_row_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       rows_checked_o
);

  localparam int DIM = DEF_MAX_DIM;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    word_t            q_rx;
    word_t            lambda_rx;
    word_t            q_rinvx;
    word_t            lambda_rinvx;
    logic             last;
  } row_result_t;

  word_t q_mem [DIM][DIM];
  word_t r_mem [DIM][DIM];
  word_t rinv_mem [DIM][DIM];
  word_t x_mem [DIM];
  word_t rx_mem [DIM];
  word_t rinvx_mem [DIM];

  logic [SIZE_W-1:0] size_cfg = SIZE_RESET;
  word_t             scale_cfg = SCALE_RESET;

  row_result_t expected_rows [$];

  function automatic longint fx_mul(input word_t a, input word_t b);
    longint wide_a;
    longint wide_b;
    wide_a = a;
    wide_b = b;
    return (wide_a * wide_b) >>> FRAC_W;
  endfunction

  function automatic word_t clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic word_t dot_row(input word_t m [DIM][DIM], input word_t v [DIM],
                                    input int i, input int n);
    longint acc;
    acc = 0;
    for (int j = 0; j < n; j++) begin
      acc += fx_mul(m[i][j], v[j]);
    end
    return clamp32(acc);
  endfunction

  function automatic int active_dim();
    int n;
    n = int'(size_cfg);
    if (n < 1) n = 1;
    if (n > DIM) n = DIM;
    if (n > MAX_OUT) n = MAX_OUT;
    return n;
  endfunction

  function automatic void run_compute();
    int n;
    row_result_t exp_row;
    n = active_dim();
    for (int i = 0; i < n; i++) begin
      rx_mem[i] = dot_row(r_mem, x_mem, i, n);
      rinvx_mem[i] = dot_row(rinv_mem, x_mem, i, n);
    end
    for (int i = 0; i < n; i++) begin
      exp_row.row = ROW_W'(i);
      exp_row.q_rx = dot_row(q_mem, rx_mem, i, n);
      exp_row.lambda_rx = clamp32(fx_mul(scale_cfg, rx_mem[i]));
      exp_row.q_rinvx = dot_row(q_mem, rinvx_mem, i, n);
      exp_row.lambda_rinvx = clamp32(fx_mul(scale_cfg, rinvx_mem[i]));
      exp_row.last = (i == n - 1);
      expected_rows.push_back(exp_row);
    end
  endfunction

  task automatic take_command();
    case (func_i)
      FUNC_LOAD_Q: q_mem[row_index_i][col_index_i] = element_value_i;
      FUNC_LOAD_R: r_mem[row_index_i][col_index_i] = element_value_i;
      FUNC_LOAD_RINV: rinv_mem[row_index_i][col_index_i] = element_value_i;
      FUNC_LOAD_X: x_mem[row_index_i] = element_value_i;
      FUNC_COMPUTE: run_compute();
      default: ;
    endcase
  endtask

  task automatic check_row();
    row_result_t want;
    row_result_t got;
    got.row = out_row_i;
    got.q_rx = q_rx_i;
    got.lambda_rx = lambda_rx_i;
    got.q_rinvx = q_rinvx_i;
    got.lambda_rinvx = lambda_rinvx_i;
    got.last = last_row_i;
    rows_checked_o++;
    if (expected_rows.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: result transfer with nothing expected, row %0d", $realtime, got.row);
      end
      return;
    end
    want = expected_rows.pop_front();
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: mismatch expected row %0d q_rx %h lambda_rx %h q_rinvx %h",
                 $realtime, want.row, want.q_rx, want.lambda_rx, want.q_rinvx);
        $display("    lambda_rinvx %h last %b / actual row %0d q_rx %h lambda_rx %h",
                 want.lambda_rinvx, want.last, got.row, got.q_rx, got.lambda_rx);
        $display("    q_rinvx %h lambda_rinvx %h last %b",
                 got.q_rinvx, got.lambda_rinvx, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg = SIZE_RESET;
      scale_cfg = SCALE_RESET;
      expected_rows.delete();
      fail_count_o = 0;
      rows_checked_o = 0;
    end else begin
      if (strobe_i) begin
        check_row();
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MATRIX_SIZE) begin
          size_cfg = cfg_data_i[SIZE_W-1:0];
        end else if (cfg_idx_i == REG_SCALE) begin
          scale_cfg = cfg_data_i;
        end
      end
      if (start_i && !busy_i) begin
        take_command();
      end
    end
    pending_o = expected_rows.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the chained matrix-vector product testbench: clock, reset and command stimulus.
// Instantiates the block and cmvp_checker, and gives the verdict. Depends on cmvp_pkg.
module tb_top;
  import cmvp_pkg::*;

  localparam int DIM           = DEF_MAX_DIM;
  localparam int RANDOM_ITEMS  = 300;
  localparam int GAP_PERCENT   = 23;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 160;
  localparam int SMALL_SPAN    = 32'h0004_0000;
  localparam int MID_SPAN      = 32'h0100_0000;

  localparam logic [FUNC_W-1:0]        FUNC_LAST = '1;
  localparam logic signed [DATA_W-1:0] FX_MAX    = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] FX_MIN    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] FX_ONE    = 32'sh0001_0000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FUNC_W-1:0]        func_i = '0;
  logic [ROW_W-1:0]         row_index_i = '0;
  logic [ROW_W-1:0]         col_index_i = '0;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;
  logic                     strobe_o;
  logic [ROW_W-1:0]         out_row_o;
  logic signed [DATA_W-1:0] q_rx_o;
  logic signed [DATA_W-1:0] lambda_rx_o;
  logic signed [DATA_W-1:0] q_rinvx_o;
  logic signed [DATA_W-1:0] lambda_rinvx_o;
  logic                     last_row_o;

  int fail_count;
  int pending;
  int rows_checked;

  bit gaps_on = 1'b1;
  int active_n = DIM;
  int commands_sent = 0;
  int computes_sent = 0;
  int ignored_sent = 0;
  int reg_writes = 0;

  bit q_set [DIM][DIM];
  bit r_set [DIM][DIM];
  bit rinv_set [DIM][DIM];
  bit x_set [DIM];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  chained_matrix_vector_product i_dut (.*);

  cmvp_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .strobe_i       (strobe_o),
    .out_row_i      (out_row_o),
    .q_rx_i         (q_rx_o),
    .lambda_rx_i    (lambda_rx_o),
    .q_rinvx_i      (q_rinvx_o),
    .lambda_rinvx_i (lambda_rinvx_o),
    .last_row_i     (last_row_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .rows_checked_o (rows_checked)
  );

  function automatic logic signed [DATA_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 5))
        0: return FX_MAX;
        1: return FX_MIN;
        2: return FX_ONE;
        3: return -FX_ONE;
        4: return '1;
        default: return '0;
      endcase
    end
    if (pick < 35) return $urandom();
    if (pick < 55) return int'($urandom_range(0, 2 * MID_SPAN)) - MID_SPAN;
    return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
  endfunction

  // The command stays on the bus until the transfer completes.
  task automatic send(input logic [FUNC_W-1:0] func, input int row, input int col,
                      input logic signed [DATA_W-1:0] value);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= func;
    row_index_i <= ROW_W'(row);
    col_index_i <= ROW_W'(col);
    element_value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    commands_sent++;
    case (func)
      FUNC_LOAD_Q: q_set[row][col] = 1'b1;
      FUNC_LOAD_R: r_set[row][col] = 1'b1;
      FUNC_LOAD_RINV: rinv_set[row][col] = 1'b1;
      FUNC_LOAD_X: x_set[row] = 1'b1;
      FUNC_COMPUTE: computes_sent++;
      default: ignored_sent++;
    endcase
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    start <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    if (idx == REG_MATRIX_SIZE) begin
      active_n = int'(data[SIZE_W-1:0]);
      if (active_n < 1) active_n = 1;
      if (active_n > DIM) active_n = DIM;
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // A compute must only read entries that were loaded since reset.
  task automatic fill_needed();
    for (int r = 0; r < active_n; r++) begin
      if (!x_set[r]) send(FUNC_LOAD_X, r, $urandom_range(0, DIM - 1), rand_value());
      for (int c = 0; c < active_n; c++) begin
        if (!q_set[r][c]) send(FUNC_LOAD_Q, r, c, rand_value());
        if (!r_set[r][c]) send(FUNC_LOAD_R, r, c, rand_value());
        if (!rinv_set[r][c]) send(FUNC_LOAD_RINV, r, c, rand_value());
      end
    end
  endtask

  task automatic random_loads(input int count);
    int row;
    int col;
    logic [FUNC_W-1:0] func;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        func = FUNC_W'($urandom_range(FUNC_COMPUTE + 1, FUNC_LAST));
      end else begin
        func = FUNC_W'($urandom_range(FUNC_LOAD_Q, FUNC_LOAD_X));
      end
      if ($urandom_range(0, 4) == 0) begin
        row = $urandom_range(0, DIM - 1);
        col = $urandom_range(0, DIM - 1);
      end else begin
        row = $urandom_range(0, active_n - 1);
        col = $urandom_range(0, active_n - 1);
      end
      send(func, row, col, rand_value());
    end
  endtask

  initial begin
    int phase;
    int base;
    logic [DATA_W-1:0] size_word;
    logic [DATA_W-1:0] scale_word;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_reg(REG_MATRIX_SIZE, 32'hffff_fff2);
    set_reg(REG_SCALE, SCALE_RESET);
    send(FUNC_LOAD_Q, 0, 0, FX_MAX);
    send(FUNC_LOAD_Q, 0, 1, FX_MIN);
    send(FUNC_LOAD_Q, 1, 0, FX_ONE);
    send(FUNC_LOAD_Q, 1, 1, -FX_ONE);
    send(FUNC_LOAD_R, 0, 0, FX_ONE);
    send(FUNC_LOAD_R, 0, 1, 32'sh0000_8000);
    send(FUNC_LOAD_R, 1, 0, 32'shfffe_0000);
    send(FUNC_LOAD_R, 1, 1, 32'sh0003_4000);
    send(FUNC_LOAD_RINV, 0, 0, FX_MAX);
    send(FUNC_LOAD_RINV, 0, 1, FX_MAX);
    send(FUNC_LOAD_RINV, 1, 0, FX_MIN);
    send(FUNC_LOAD_RINV, 1, 1, FX_MIN);
    send(FUNC_LOAD_X, 0, 0, 32'sh0003_0000);
    send(FUNC_LOAD_X, 1, DIM - 1, '1);
    send(FUNC_COMPUTE, 0, 0, '0);
    for (int f = FUNC_COMPUTE + 1; f <= FUNC_LAST; f++) begin
      send(FUNC_W'(f), $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), $urandom());
    end
    send(FUNC_LOAD_Q, DIM - 1, DIM - 1, FX_MAX);
    send(FUNC_LOAD_X, DIM - 1, 0, FX_MIN);
    send(FUNC_LOAD_R, DIM - 1, 0, '0);
    send(FUNC_COMPUTE, DIM - 1, DIM - 1, FX_MIN);
    settle();
    set_reg(REG_MATRIX_SIZE, '0);
    send(FUNC_COMPUTE, 0, 0, '0);
    settle();
    set_reg(REG_SCALE, FX_MIN);
    send(FUNC_COMPUTE, 0, 0, '0);
    settle();
    set_reg(REG_SCALE, FX_MAX);
    send(FUNC_COMPUTE, 0, 0, '0);

    base = commands_sent - ignored_sent;
    phase = 0;
    while (phase < 8 || commands_sent - ignored_sent - base < RANDOM_ITEMS) begin
      gaps_on = (phase != 3);
      size_word = $urandom();
      case (phase)
        2: size_word[SIZE_W-1:0] = '0;
        5: size_word[SIZE_W-1:0] = '1;
        6: size_word[SIZE_W-1:0] = SIZE_W'(DIM);
        default: begin
          if ($urandom_range(0, 9) < 7) begin
            size_word[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 3));
          end else begin
            size_word[SIZE_W-1:0] = SIZE_W'($urandom_range(4, DIM - 1));
          end
        end
      endcase
      case (phase % 6)
        0: scale_word = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
        1: scale_word = FX_MAX;
        2: scale_word = FX_MIN;
        3: scale_word = '0;
        4: scale_word = $urandom();
        default: scale_word = SCALE_RESET;
      endcase
      settle();
      set_reg(REG_MATRIX_SIZE, size_word);
      set_reg(REG_SCALE, scale_word);
      repeat ($urandom_range(3, 6)) begin
        random_loads($urandom_range(0, 4));
        fill_needed();
        if ($urandom_range(0, 7) == 0) settle();
        send(FUNC_COMPUTE, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), $urandom());
      end
      phase++;
    end

    gaps_on = 1'b1;
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d commands: %0d computes, %0d with unused codes, %0d register writes.",
             commands_sent, computes_sent, ignored_sent, reg_writes);
    $display("%0d result rows compared, %0d failures, %0d rows still expected.",
             rows_checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: the run did not complete.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
